@@ hw/rtl/nsp_pkg.sv @@
`timescale 1ns / 1ps

package nsp_pkg;

  // line store size, one place kept for the end of the line
  localparam int LINE_CAPACITY = 128;
  localparam int LEN_W = $clog2(LINE_CAPACITY);

  // characters
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_G       = 8'h47;
  localparam logic [7:0] CH_M       = 8'h4D;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  // pair of ascii digits: c*10 + d - 528, modulo 256
  localparam logic [7:0] PAIR_BIAS = 8'd16;

  typedef enum logic [1:0] {
    LS_REJECT = 2'd0,
    LS_RMC    = 2'd1,
    LS_GGA    = 2'd2,
    LS_OTHER  = 2'd3
  } line_status_t;

  // what the scanner knows about the line when its LF arrives
  typedef struct packed {
    logic        accepted;
    logic        is_rmc;
    logic        is_gga;
    logic        status_a;
    logic        time_ok;
    logic [23:0] time_val;
    logic        date_ok;
    logic [23:0] date_val;
    logic        quality_ok;
    logic [7:0]  quality;
    logic        sats_ok;
    logic [7:0]  sats;
  } line_summary_t;

  function automatic logic [7:0] times_ten(input logic [7:0] v);
    times_ten = {v[4:0], 3'b000} + {v[6:0], 1'b0};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    hex_nibble = 5'd0;
    if (is_digit(c)) begin
      v = c - CH_0;
      hex_nibble = {1'b1, v[3:0]};
    end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
      v = c - CH_UPPER_A + 8'd10;
      hex_nibble = {1'b1, v[3:0]};
    end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
      v = c - CH_LOWER_A + 8'd10;
      hex_nibble = {1'b1, v[3:0]};
    end
  endfunction

endpackage

@@ hw/rtl/nsp_line_scan.sv @@
`timescale 1ns / 1ps

module nsp_line_scan
  import nsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data,
  output line_summary_t summary
);

  localparam logic [3:0] FIELD_TIME    = 4'd0;
  localparam logic [3:0] FIELD_STATUS  = 4'd1;
  localparam logic [3:0] FIELD_QUALITY = 4'd5;
  localparam logic [3:0] FIELD_SATS    = 4'd6;
  localparam logic [3:0] FIELD_DATE    = 4'd8;

  typedef enum logic [2:0] {
    SP_START, SP_SUM, SP_HEX1, SP_HEX2, SP_OK, SP_BAD
  } sum_phase_t;

  typedef enum logic [1:0] {
    DEC_IDLE, DEC_BLANK, DEC_DIGIT
  } dec_phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    logic             content_ended;
    sum_phase_t       phase;
    logic [7:0]       checksum_accum;
    logic [3:0]       expected_hi;
    logic             id_rmc;
    logic             id_gga;
    logic             id_done;
    logic [3:0]       comma_count;
    logic             field_pending;
    logic [2:0]       cap_cnt;
    logic             cap_date;
    logic [7:0]       cap_partial;
    logic [23:0]      time_val;
    logic             time_ok;
    logic [23:0]      date_val;
    logic             date_ok;
    logic             status_a;
    dec_phase_t       dec_phase;
    logic             dec_sats;
    logic [7:0]       q_acc;
    logic             q_neg;
    logic             q_present;
    logic [7:0]       s_acc;
    logic             s_neg;
    logic             s_present;
  } scan_t;

  scan_t      st;
  scan_t      st_next;

  logic       overflow;
  logic [4:0] hex;
  logic [3:0] fidx;
  logic       fstart;
  logic       cap_run;
  logic [2:0] cap_idx;
  logic       cap_to_date;
  logic [23:0] cap_vec;
  logic [7:0] pair;
  logic       dec_start;
  dec_phase_t d_phase;
  logic       d_sats;
  logic [7:0] d_acc;
  logic       d_neg;

  assign overflow = (st.line_length == LEN_W'(LINE_CAPACITY - 1));
  assign hex      = hex_nibble(data);

  always_comb begin
    st_next     = st;
    fidx        = st.comma_count - 4'd1;
    fstart      = 1'b0;
    cap_run     = 1'b0;
    cap_idx     = st.cap_cnt;
    cap_to_date = st.cap_date;
    cap_vec     = 24'd0;
    pair        = st.cap_partial + data - PAIR_BIAS;
    dec_start   = 1'b0;
    d_phase     = st.dec_phase;
    d_sats      = st.dec_sats;
    d_acc       = 8'd0;
    d_neg       = 1'b0;

    if (step && (data != CH_CR)) begin
      if ((data == CH_LF) || overflow) begin
        st_next = '0;
      end else begin
        st_next.line_length = st.line_length + LEN_W'(1);
        if (!st.content_ended) begin
          if (data == CH_NUL) begin
            st_next.content_ended = 1'b1;
          end else begin
            // checksum over the text between '$' and '*'
            unique case (st.phase)
              SP_START: st_next.phase = (data == CH_DOLLAR) ? SP_SUM : SP_BAD;
              SP_SUM: begin
                if (data == CH_STAR) st_next.phase = SP_HEX1;
                else st_next.checksum_accum = st.checksum_accum ^ data;
              end
              SP_HEX1: begin
                if (hex[4]) begin
                  st_next.expected_hi = hex[3:0];
                  st_next.phase = SP_HEX2;
                end else begin
                  st_next.phase = SP_BAD;
                end
              end
              SP_HEX2: begin
                st_next.phase = (hex[4] && (st.checksum_accum == {st.expected_hi, hex[3:0]}))
                                ? SP_OK : SP_BAD;
              end
              SP_OK, SP_BAD: ;
              default: st_next.phase = SP_BAD;
            endcase

            // sentence id: GP or GN talker, then RMC or GGA
            unique case (st.line_length)
              LEN_W'(0): begin
                st_next.id_rmc = 1'b1;
                st_next.id_gga = 1'b1;
              end
              LEN_W'(1): begin
                st_next.id_rmc = st.id_rmc && (data == CH_G);
                st_next.id_gga = st.id_gga && (data == CH_G);
              end
              LEN_W'(2): begin
                st_next.id_rmc = st.id_rmc && ((data == CH_P) || (data == CH_N));
                st_next.id_gga = st.id_gga && ((data == CH_P) || (data == CH_N));
              end
              LEN_W'(3): begin
                st_next.id_rmc = st.id_rmc && (data == CH_R);
                st_next.id_gga = st.id_gga && (data == CH_G);
              end
              LEN_W'(4): begin
                st_next.id_rmc = st.id_rmc && (data == CH_M);
                st_next.id_gga = st.id_gga && (data == CH_G);
              end
              LEN_W'(5): begin
                st_next.id_rmc  = st.id_rmc && (data == CH_C);
                st_next.id_gga  = st.id_gga && (data == CH_UPPER_A);
                st_next.id_done = 1'b1;
              end
              default: ;
            endcase

            // field n opens after comma n+1 unless it is empty
            fstart = st.field_pending && (data != CH_COMMA) && (data != CH_STAR);
            st_next.field_pending = (data == CH_COMMA);
            if ((data == CH_COMMA) && (st.comma_count != 4'hF)) begin
              st_next.comma_count = st.comma_count + 4'd1;
            end

            if (fstart && (fidx == FIELD_STATUS)) begin
              st_next.status_a = (data == CH_UPPER_A);
            end

            // six character capture for time and date
            if (fstart && ((fidx == FIELD_TIME) || (fidx == FIELD_DATE))) begin
              cap_run     = 1'b1;
              cap_idx     = 3'd0;
              cap_to_date = (fidx == FIELD_DATE);
            end else if (st.cap_cnt != 3'd0) begin
              cap_run = 1'b1;
            end
            if (cap_run) begin
              cap_vec = cap_to_date ? st.date_val : st.time_val;
              st_next.cap_date = cap_to_date;
              if (!cap_idx[0]) begin
                st_next.cap_partial = times_ten(data);
              end else begin
                unique case (cap_idx[2:1])
                  2'd0: cap_vec[23:16] = pair;
                  2'd1: cap_vec[15:8]  = pair;
                  2'd2: cap_vec[7:0]   = pair;
                  default: ;
                endcase
              end
              if (cap_to_date) st_next.date_val = cap_vec;
              else st_next.time_val = cap_vec;
              if (cap_idx == 3'd5) begin
                st_next.cap_cnt = 3'd0;
                if (cap_to_date) st_next.date_ok = 1'b1;
                else st_next.time_ok = 1'b1;
              end else begin
                st_next.cap_cnt = cap_idx + 3'd1;
              end
            end

            // decimal number for fix quality and satellite count
            dec_start = fstart && ((fidx == FIELD_QUALITY) || (fidx == FIELD_SATS));
            if (dec_start) begin
              d_phase = DEC_BLANK;
              d_sats  = (fidx == FIELD_SATS);
            end else begin
              d_acc = st.dec_sats ? st.s_acc : st.q_acc;
              d_neg = st.dec_sats ? st.s_neg : st.q_neg;
            end
            unique case (d_phase)
              DEC_IDLE: ;
              DEC_BLANK: begin
                if (is_blank(data)) begin
                  d_phase = DEC_BLANK;
                end else if ((data == CH_MINUS) || (data == CH_PLUS)) begin
                  d_neg   = (data == CH_MINUS);
                  d_phase = DEC_DIGIT;
                end else if (is_digit(data)) begin
                  d_acc   = data - CH_0;
                  d_phase = DEC_DIGIT;
                end else begin
                  d_phase = DEC_IDLE;
                end
              end
              DEC_DIGIT: begin
                if (is_digit(data)) d_acc = times_ten(d_acc) + (data - CH_0);
                else d_phase = DEC_IDLE;
              end
              default: d_phase = DEC_IDLE;
            endcase
            st_next.dec_phase = d_phase;
            st_next.dec_sats  = d_sats;
            if (dec_start || (st.dec_phase != DEC_IDLE)) begin
              if (d_sats) begin
                st_next.s_acc = d_acc;
                st_next.s_neg = d_neg;
                st_next.s_present = 1'b1;
              end else begin
                st_next.q_acc = d_acc;
                st_next.q_neg = d_neg;
                st_next.q_present = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    summary.accepted   = (st.phase == SP_OK);
    summary.is_rmc     = st.id_done && st.id_rmc;
    summary.is_gga     = st.id_done && st.id_gga;
    summary.status_a   = st.status_a;
    summary.time_ok    = st.time_ok;
    summary.time_val   = st.time_val;
    summary.date_ok    = st.date_ok;
    summary.date_val   = st.date_val;
    summary.quality_ok = st.q_present;
    summary.quality    = st.q_neg ? (8'd0 - st.q_acc) : st.q_acc;
    summary.sats_ok    = st.s_present;
    summary.sats       = st.s_neg ? (8'd0 - st.s_acc) : st.s_acc;
  end

endmodule

@@ hw/rtl/nsp_record.sv @@
`timescale 1ns / 1ps

module nsp_record
  import nsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          line_end,
  input  line_summary_t summary,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [1:0]    line_status,
  output logic          committed,
  output logic          fix_valid,
  output logic [7:0]    utc_hour,
  output logic [7:0]    utc_minute,
  output logic [7:0]    utc_second,
  output logic [7:0]    date_day,
  output logic [7:0]    date_month,
  output logic [7:0]    date_year,
  output logic [7:0]    fix_quality,
  output logic [7:0]    satellite_count
);

  line_status_t status_q;
  line_status_t status_next;
  logic         commit;

  logic        staged_status_ok, staged_status_ok_next;
  logic [23:0] staged_time, staged_time_next;
  logic [23:0] staged_date, staged_date_next;
  logic [7:0]  staged_quality, staged_quality_next;
  logic [7:0]  staged_sats, staged_sats_next;
  logic        rmc_seen, rmc_seen_next;
  logic        gga_seen, gga_seen_next;

  logic        held_valid;
  logic [23:0] held_time;
  logic [23:0] held_date;
  logic [15:0] held_quality_sats;

  always_comb begin
    status_next           = LS_REJECT;
    commit                = 1'b0;
    staged_status_ok_next = staged_status_ok;
    staged_time_next      = staged_time;
    staged_date_next      = staged_date;
    staged_quality_next   = staged_quality;
    staged_sats_next      = staged_sats;
    rmc_seen_next         = rmc_seen;
    gga_seen_next         = gga_seen;
    if (line_end && summary.accepted) begin
      priority if (summary.is_rmc) begin
        status_next = LS_RMC;
        if (summary.status_a) begin
          staged_status_ok_next = 1'b1;
          if (summary.time_ok) staged_time_next = summary.time_val;
          if (summary.date_ok) staged_date_next = summary.date_val;
          rmc_seen_next = 1'b1;
        end else begin
          staged_status_ok_next = 1'b0;
        end
      end else if (summary.is_gga) begin
        status_next = LS_GGA;
        if (summary.quality_ok) staged_quality_next = summary.quality;
        if (summary.sats_ok) staged_sats_next = summary.sats;
        gga_seen_next = 1'b1;
      end else begin
        status_next = LS_OTHER;
      end
      commit = rmc_seen_next && gga_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      status_q          <= LS_REJECT;
      committed         <= 1'b0;
      staged_status_ok  <= 1'b0;
      staged_time       <= 24'd0;
      staged_date       <= 24'd0;
      staged_quality    <= 8'd0;
      staged_sats       <= 8'd0;
      rmc_seen          <= 1'b0;
      gga_seen          <= 1'b0;
      held_valid        <= 1'b0;
      held_time         <= 24'd0;
      held_date         <= 24'd0;
      held_quality_sats <= 16'd0;
    end else begin
      if (line_end) begin
        out_valid <= 1'b1;
        status_q  <= status_next;
        committed <= commit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      staged_status_ok <= staged_status_ok_next;
      staged_time      <= staged_time_next;
      staged_date      <= staged_date_next;
      staged_quality   <= staged_quality_next;
      staged_sats      <= staged_sats_next;
      if (commit) begin
        rmc_seen          <= 1'b0;
        gga_seen          <= 1'b0;
        held_valid        <= staged_status_ok_next;
        held_time         <= staged_time_next;
        held_date         <= staged_date_next;
        held_quality_sats <= {staged_quality_next, staged_sats_next};
      end else begin
        rmc_seen <= rmc_seen_next;
        gga_seen <= gga_seen_next;
      end
    end
  end

  // the held record only moves together with a new result, so it doubles
  // as the output register
  assign line_status     = status_q;
  assign fix_valid       = held_valid;
  assign utc_hour        = held_time[23:16];
  assign utc_minute      = held_time[15:8];
  assign utc_second      = held_time[7:0];
  assign date_day        = held_date[23:16];
  assign date_month      = held_date[15:8];
  assign date_year       = held_date[7:0];
  assign fix_quality     = held_quality_sats[15:8];
  assign satellite_count = held_quality_sats[7:0];

endmodule

@@ hw/rtl/nmea_sentence_parser.sv @@
`timescale 1ns / 1ps

// channel  | handshake            | word
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_ready  | rx_byte, one stream character
// out      | out_valid / out_ready| line_status, committed, held record
//
// one character per cycle, sustained while no LF waits; the result is registered
// from the LF in the input register and the per-line scan state
// only an LF needs the result register, so an LF waits in the input register
// while an earlier result is still untaken; other characters keep flowing
// reset is synchronous and clears the line, the staged and the held record
// CR never changes state; a character beyond the line store restarts the line

module nmea_sentence_parser
  import nsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] line_status,
  output logic       committed,
  output logic       fix_valid,
  output logic [7:0] utc_hour,
  output logic [7:0] utc_minute,
  output logic [7:0] utc_second,
  output logic [7:0] date_day,
  output logic [7:0] date_month,
  output logic [7:0] date_year,
  output logic [7:0] fix_quality,
  output logic [7:0] satellite_count
);

  // input register
  logic [7:0]    byte_q;
  logic          byte_valid;

  logic          advance;
  logic          line_end;
  line_summary_t summary;

  // an LF may only move on when the result register is free or draining
  assign advance  = byte_valid && ((byte_q != CH_LF) || !out_valid || out_ready);
  assign line_end = advance && (byte_q == CH_LF);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  // running checksum, sentence id, comma count and field capture
  nsp_line_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .data    (byte_q),
    .summary (summary)
  );

  // staged and held record, commit and result register
  nsp_record u_record (
    .clk             (clk),
    .rst             (rst),
    .line_end        (line_end),
    .summary         (summary),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .line_status     (line_status),
    .committed       (committed),
    .fix_valid       (fix_valid),
    .utc_hour        (utc_hour),
    .utc_minute      (utc_minute),
    .utc_second      (utc_second),
    .date_day        (date_day),
    .date_month      (date_month),
    .date_year       (date_year),
    .fix_quality     (fix_quality),
    .satellite_count (satellite_count)
  );

endmodule

@@ hw/rtl/nsp_checker.sv @@
`timescale 1ns / 1ps

module nsp_checker
  import nsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] line_status,
  input logic       committed,
  input logic       fix_valid,
  input logic [7:0] utc_hour,
  input logic [7:0] utc_minute,
  input logic [7:0] utc_second,
  input logic [7:0] date_day,
  input logic [7:0] date_month,
  input logic [7:0] date_year,
  input logic [7:0] fix_quality,
  input logic [7:0] satellite_count
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_status) && $stable(committed)
      && $stable(utc_hour) && $stable(satellite_count))
    else $error("result changed while stalled");

  // the input only stalls behind an untaken result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // a commit can only come from an accepted RMC or GGA line
  a_commit_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && committed |-> (line_status == LS_RMC) || (line_status == LS_GGA))
    else $error("commit on a line that is not RMC or GGA");

  // the held record moves only with a committing result
  a_held_moves: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !($stable(fix_valid) && $stable(utc_hour) && $stable(utc_minute)
      && $stable(utc_second) && $stable(date_day) && $stable(date_month)
      && $stable(date_year) && $stable(fix_quality) && $stable(satellite_count))
    |-> out_valid && committed)
    else $error("held record changed without a commit");

endmodule

bind nmea_sentence_parser nsp_checker u_checker (.*);

@@ tb/nmea_scoreboard_pkg.sv @@
`timescale 1ns / 1ps

package nmea_scoreboard_pkg;
  import nsp_pkg::*;

  typedef struct {
    line_status_t status;
    logic         committed;
    logic         fix_valid;
    logic [7:0]   hour;
    logic [7:0]   minute;
    logic [7:0]   second;
    logic [7:0]   day;
    logic [7:0]   month;
    logic [7:0]   year;
    logic [7:0]   quality;
    logic [7:0]   sats;
  } nmea_report_t;

  class nmea_scoreboard;
    logic [7:0]   line_buf [LINE_CAPACITY];
    int unsigned  line_len;
    int unsigned  content_len;
    logic         staged_ok;
    logic [23:0]  staged_time;
    logic [23:0]  staged_date;
    logic [7:0]   staged_quality;
    logic [7:0]   staged_sats;
    logic         held_valid;
    logic [23:0]  held_time;
    logic [23:0]  held_date;
    logic [7:0]   held_quality;
    logic [7:0]   held_sats;
    logic         rmc_seen;
    logic         gga_seen;
    nmea_report_t pending [$];
    int unsigned  errors;

    function new();
      foreach (line_buf[i]) line_buf[i] = CH_NUL;
      line_len = 0;
      content_len = 0;
      staged_ok = 1'b0;
      staged_time = '0;
      staged_date = '0;
      staged_quality = '0;
      staged_sats = '0;
      held_valid = 1'b0;
      held_time = '0;
      held_date = '0;
      held_quality = '0;
      held_sats = '0;
      rmc_seen = 1'b0;
      gga_seen = 1'b0;
      errors = 0;
    endfunction

    function logic [7:0] char_at(int unsigned i);
      return (i < content_len && i < LINE_CAPACITY) ? line_buf[i] : CH_NUL;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return c - CH_0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return c - CH_UPPER_A + 10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return c - CH_LOWER_A + 10;
      return -1;
    endfunction

    // xor of the text between the dollar and the star against the two hex digits
    function bit sum_matches();
      int unsigned p;
      logic [7:0]  acc;
      int          hi;
      int          lo;
      p = 1;
      acc = '0;
      if (char_at(0) != CH_DOLLAR) return 1'b0;
      while (char_at(p) != CH_NUL && char_at(p) != CH_STAR) begin
        acc ^= char_at(p);
        p++;
      end
      if (char_at(p) != CH_STAR) return 1'b0;
      p++;
      if (char_at(p) == CH_NUL || char_at(p + 1) == CH_NUL) return 1'b0;
      hi = hex_digit(char_at(p));
      lo = hex_digit(char_at(p + 1));
      if (hi < 0 || lo < 0) return 1'b0;
      return acc == 8'((hi << 4) | lo);
    endfunction

    function bit talker_is(string id);
      int i;
      for (i = 0; i < 5; i++)
        if (char_at(i + 1) != id[i]) return 1'b0;
      return 1'b1;
    endfunction

    // start of field n, -1 when missing or empty
    function int field_start(int unsigned n);
      int unsigned p;
      int unsigned k;
      logic [7:0]  c;
      p = 0;
      k = 0;
      while (char_at(p) != CH_NUL && char_at(p) != CH_COMMA) p++;
      if (char_at(p) == CH_COMMA) p++;
      while (k < n && char_at(p) != CH_NUL) begin
        while (char_at(p) != CH_NUL && char_at(p) != CH_COMMA) p++;
        if (char_at(p) == CH_COMMA) begin
          p++;
          k++;
        end
      end
      c = char_at(p);
      if (k != n || c == CH_NUL || c == CH_COMMA || c == CH_STAR) return -1;
      return p;
    endfunction

    function logic [7:0] digit_pair(int unsigned p);
      int unsigned v;
      v = char_at(p) * 10 + char_at(p + 1) - 528;
      return v[7:0];
    endfunction

    function bit six_digits(int f, output logic [23:0] v);
      if (f < 0) return 1'b0;
      if (content_len < f + 6) return 1'b0;
      v = {digit_pair(f), digit_pair(f + 2), digit_pair(f + 4)};
      return 1'b1;
    endfunction

    function logic [7:0] decimal_value(int unsigned p);
      logic [7:0] acc;
      logic [7:0] c;
      bit         neg;
      acc = '0;
      neg = 1'b0;
      c = char_at(p);
      while (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
        p++;
        c = char_at(p);
      end
      if (c == CH_MINUS || c == CH_PLUS) begin
        neg = (c == CH_MINUS);
        p++;
      end
      while (char_at(p) >= CH_0 && char_at(p) <= CH_9) begin
        acc = acc * 8'd10 + (char_at(p) - CH_0);
        p++;
      end
      if (neg) acc = 8'd0 - acc;
      return acc;
    endfunction

    function void end_of_line();
      nmea_report_t r;
      int           f;
      logic [23:0]  v;
      content_len = 0;
      while (content_len < line_len && content_len < LINE_CAPACITY &&
             line_buf[content_len] != CH_NUL)
        content_len++;
      line_len = 0;
      r.status = LS_REJECT;
      r.committed = 1'b0;
      if (sum_matches()) begin
        if (talker_is("GPRMC") || talker_is("GNRMC")) begin
          r.status = LS_RMC;
          f = field_start(1);
          if (f < 0 || char_at(f) != CH_UPPER_A) begin
            staged_ok = 1'b0;
          end else begin
            staged_ok = 1'b1;
            if (six_digits(field_start(0), v)) staged_time = v;
            if (six_digits(field_start(8), v)) staged_date = v;
            rmc_seen = 1'b1;
          end
        end else if (talker_is("GPGGA") || talker_is("GNGGA")) begin
          r.status = LS_GGA;
          f = field_start(5);
          if (f >= 0) staged_quality = decimal_value(f);
          f = field_start(6);
          if (f >= 0) staged_sats = decimal_value(f);
          gga_seen = 1'b1;
        end else begin
          r.status = LS_OTHER;
        end
        if (rmc_seen && gga_seen) begin
          held_valid = staged_ok;
          held_time = staged_time;
          held_date = staged_date;
          held_quality = staged_quality;
          held_sats = staged_sats;
          rmc_seen = 1'b0;
          gga_seen = 1'b0;
          r.committed = 1'b1;
        end
      end
      content_len = 0;
      r.fix_valid = held_valid;
      r.hour = held_time[23:16];
      r.minute = held_time[15:8];
      r.second = held_time[7:0];
      r.day = held_date[23:16];
      r.month = held_date[15:8];
      r.year = held_date[7:0];
      r.quality = held_quality;
      r.sats = held_sats;
      pending.push_back(r);
    endfunction

    function void note_byte(logic [7:0] ch);
      if (ch == CH_CR) return;
      if (ch != CH_LF) begin
        if (line_len < LINE_CAPACITY - 1) begin
          line_buf[line_len] = ch;
          line_len++;
        end else begin
          line_len = 0;
        end
        return;
      end
      end_of_line();
    endfunction

    function void field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        // keep the log short on a badly broken block
        if (errors <= 200)
          $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(nmea_report_t got);
      nmea_report_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, line_status expected none, got %0d",
                 $time, got.status);
        return;
      end
      want = pending.pop_front();
      field_ok("line_status", want.status, got.status);
      field_ok("committed", want.committed, got.committed);
      field_ok("fix_valid", want.fix_valid, got.fix_valid);
      field_ok("utc_hour", want.hour, got.hour);
      field_ok("utc_minute", want.minute, got.minute);
      field_ok("utc_second", want.second, got.second);
      field_ok("date_day", want.day, got.day);
      field_ok("date_month", want.month, got.month);
      field_ok("date_year", want.year, got.year);
      field_ok("fix_quality", want.quality, got.quality);
      field_ok("satellite_count", want.sats, got.sats);
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import nsp_pkg::*;
  import nmea_scoreboard_pkg::*;

  // how a sentence is closed: checksum spelling or a deliberate fault
  typedef enum int {
    SUM_UPPER,
    SUM_LOWER,
    SUM_WRONG,
    SUM_MISSING,
    SUM_SHORT,
    SUM_BAD_HEX
  } sum_form_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] line_status;
  logic       committed;
  logic       fix_valid;
  logic [7:0] utc_hour;
  logic [7:0] utc_minute;
  logic [7:0] utc_second;
  logic [7:0] date_day;
  logic [7:0] date_month;
  logic [7:0] date_year;
  logic [7:0] fix_quality;
  logic [7:0] satellite_count;

  nmea_scoreboard sb;
  nmea_report_t   observed;

  // sender and receiver idle odds in percent, receiver hold-off length
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned ready_hold;

  // characters of the line being built, and running counts of sent words
  logic [7:0]  frame [$];
  int unsigned bytes_sent;
  int unsigned lines_sent;

  nmea_sentence_parser DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .line_status    (line_status),
    .committed      (committed),
    .fix_valid      (fix_valid),
    .utc_hour       (utc_hour),
    .utc_minute     (utc_minute),
    .utc_second     (utc_second),
    .date_day       (date_day),
    .date_month     (date_month),
    .date_year      (date_year),
    .fix_quality    (fix_quality),
    .satellite_count(satellite_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // both channels are watched at the rising edge: every accepted word feeds
  // the predictor, every accepted result is checked against the oldest line
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready) begin
        observed.status = line_status_t'(line_status);
        observed.committed = committed;
        observed.fix_valid = fix_valid;
        observed.hour = utc_hour;
        observed.minute = utc_minute;
        observed.second = utc_second;
        observed.day = date_day;
        observed.month = date_month;
        observed.year = date_year;
        observed.quality = fix_quality;
        observed.sats = satellite_count;
        sb.check_report(observed);
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one word, with random gaps first; returns at the falling edge
  // after the word was taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (b != CH_CR) bytes_sent++;
    if (b == CH_LF) lines_sent++;
    @(negedge clk);
  endtask

  // sends the built line; a stray CR may slip in anywhere, it must not matter
  task automatic send_frame();
    foreach (frame[i]) begin
      if ($urandom_range(49) == 0) send_byte(CH_CR);
      send_byte(frame[i]);
    end
    frame.delete();
  endtask

  function automatic void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) frame.push_back(s.getc(i));
  endfunction

  function automatic void put_rmc(string talker, string t, string status, string d);
    put_text({"$", talker, "RMC,", t, ",", status,
              ",4807.038,N,01131.000,E,022.4,084.4,", d, ",003.1,W"});
  endfunction

  function automatic void put_gga(string talker, string t, string q, string s);
    put_text({"$", talker, "GGA,", t, ",4807.038,N,01131.000,E,", q, ",", s,
              ",0.9,545.4,M,46.9,M,,"});
  endfunction

  // checksum over the text after the last dollar, then the trailing text, an
  // optional zero byte inserted at a given place and the LF
  task automatic finish_line(sum_form_t form, int zero_at = -1, string tail = "");
    logic [7:0] sum;
    int         from_idx;
    int         i;
    sum = '0;
    from_idx = 0;
    foreach (frame[j]) if (frame[j] == CH_DOLLAR) from_idx = j;
    for (i = from_idx + 1; i < frame.size(); i++) sum ^= frame[i];
    case (form)
      SUM_UPPER:   put_text($sformatf("*%02X", sum));
      SUM_LOWER:   put_text($sformatf("*%02x", sum));
      SUM_WRONG:   put_text($sformatf("*%02X", sum ^ 8'($urandom_range(1, 255))));
      SUM_SHORT:   put_text($sformatf("*%X", sum[3:0]));
      SUM_BAD_HEX: put_text($sformatf("*G%X", sum[3:0]));
      SUM_MISSING: ;
      default:     ;
    endcase
    put_text(tail);
    if (zero_at >= 0 && zero_at < frame.size()) frame.insert(zero_at, CH_NUL);
    frame.push_back(CH_LF);
    send_frame();
  endtask

  // printable, but never a field or checksum delimiter nor a line start
  function automatic string safe_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126));
    while (c == CH_STAR || c == CH_COMMA || c == CH_DOLLAR);
    return $sformatf("%c", c);
  endfunction

  function automatic string digit_pair_text();
    if ($urandom_range(4) == 0) return {safe_char(), safe_char()};
    return $sformatf("%02d", $urandom_range(99));
  endfunction

  // hhmmss or ddmmyy, sometimes short, empty or with junk
  function automatic string rand_time();
    string s;
    s = "";
    case ($urandom_range(9))
      0: s = "";
      1: s = $sformatf("%0d", $urandom_range(9999));
      default: begin
        s = {digit_pair_text(), digit_pair_text(), digit_pair_text()};
        if ($urandom_range(1)) s = {s, ".00"};
      end
    endcase
    return s;
  endfunction

  function automatic string rand_status();
    case ($urandom_range(9))
      0: return "V";
      1: return "";
      2: return safe_char();
      default: return "A";
    endcase
  endfunction

  function automatic string rand_talker();
    case ($urandom_range(9))
      0: return "GL";
      1: return "gp";
      default: return $urandom_range(1) ? "GP" : "GN";
    endcase
  endfunction

  // gga number: blanks, sign and digits in every mix, wide values wrap
  function automatic string rand_number();
    string s;
    if ($urandom_range(6) == 0) return "";
    s = "";
    repeat ($urandom_range(2)) begin
      case ($urandom_range(3))
        0: s = {s, $sformatf("%c", CH_SPACE)};
        1: s = {s, $sformatf("%c", CH_TAB)};
        2: s = {s, $sformatf("%c", CH_VT)};
        default: s = {s, $sformatf("%c", CH_FF)};
      endcase
    end
    case ($urandom_range(9))
      0, 1: s = {s, "-"};
      2: s = {s, "+"};
      default: ;
    endcase
    case ($urandom_range(9))
      0: ;
      1: s = {s, $sformatf("%0d", $urandom_range(99999))};
      default: s = {s, $sformatf("%0d", $urandom_range(20))};
    endcase
    if ($urandom_range(9) == 0) s = {s, safe_char()};
    return s;
  endfunction

  function automatic sum_form_t rand_form();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return SUM_UPPER;
    if (r < 88) return SUM_LOWER;
    if (r < 92) return SUM_WRONG;
    if (r < 95) return SUM_MISSING;
    if (r < 98) return SUM_SHORT;
    return SUM_BAD_HEX;
  endfunction

  task automatic run_directed();
    // extreme time and date, then a gga completes the pair and commits
    put_rmc("GP", "235959", "A", "311299");
    finish_line(SUM_UPPER);
    put_gga("GN", "235959", "1", "08");
    finish_line(SUM_LOWER);
    // status V drops the staged flag, rmc does not count
    put_rmc("GN", "000000.00", "V", "010100");
    finish_line(SUM_UPPER);
    // negative quality, satellite count past 255, absent time
    put_gga("GP", "", " -5", "+300");
    finish_line(SUM_UPPER);
    // non-digit time characters, absent date keeps the staged one
    put_rmc("GP", "9Z:x7~", "A", "");
    finish_line(SUM_UPPER);
    // other sentence with text after the checksum digits
    put_text("$GPGSV,3,1,11");
    finish_line(SUM_UPPER, -1, "xyz");
    // checksum faults
    put_rmc("GP", "120000", "A", "150624");
    finish_line(SUM_WRONG);
    put_gga("GP", "120000", "2", "12");
    finish_line(SUM_MISSING);
    put_gga("GN", "120000", "2", "12");
    finish_line(SUM_SHORT);
    put_rmc("GN", "120000", "A", "150624");
    finish_line(SUM_BAD_HEX);
    // no leading dollar
    put_text("GPRMC,101010,A");
    finish_line(SUM_UPPER);
    // empty line
    frame.push_back(CH_LF);
    send_frame();
    // zero byte before the star cuts the checksum off, a place past the end adds none
    put_gga("GP", "1", "2", "3");
    finish_line(SUM_UPPER, 12);
    put_gga("GN", "1", "4", "5");
    finish_line(SUM_UPPER, 200);
    put_rmc("GP", "010203", "A", "040506");
    frame.push_back(CH_NUL);
    finish_line(SUM_UPPER);
    // longest line the store holds
    put_text("$GPTXT,");
    while (frame.size() < 124) frame.push_back(CH_LOWER_A);
    finish_line(SUM_UPPER);
    // one character too many restarts the line, the sentence after it counts
    repeat (LINE_CAPACITY) frame.push_back(CH_LOWER_F);
    put_gga("GP", "3", "-0", "255");
    finish_line(SUM_LOWER);
    // extreme byte values as noise
    frame.push_back(8'hFF);
    frame.push_back(8'h80);
    frame.push_back(8'h00);
    frame.push_back(8'h7F);
    frame.push_back(8'h01);
    frame.push_back(CH_LF);
    send_frame();
  endtask

  // mostly well-formed rmc and gga with random content, the rest noise,
  // overflowing lines and other sentences
  task automatic random_line();
    int unsigned r;
    int          zero_at;
    string       tail;
    r = $urandom_range(99);
    zero_at = ($urandom_range(29) == 0) ? int'($urandom_range(1, 60)) : -1;
    tail = ($urandom_range(9) == 0) ? {safe_char(), safe_char()} : "";
    if (r >= 75 && r < 88) begin
      repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom_range(255)));
      frame.push_back(CH_LF);
      send_frame();
      return;
    end
    if (r >= 88) begin
      // around the store size; exactly one over leaves a clean restart
      repeat ($urandom_range(LINE_CAPACITY - 1, LINE_CAPACITY + 1)) begin
        frame.push_back(8'(safe_char().getc(0)));
      end
      r = $urandom_range(64);
    end
    if (r < 35) begin
      put_rmc(rand_talker(), rand_time(), rand_status(), rand_time());
    end else if (r < 65) begin
      put_gga(rand_talker(), rand_time(), rand_number(), rand_number());
    end else begin
      case ($urandom_range(3))
        0: put_text("$GPGSV,");
        1: put_text("$GNVTG,");
        2: put_text("$GPGLL,");
        default: put_text("$GPTXT,");
      endcase
      put_text({rand_number(), ",", rand_time()});
    end
    finish_line(rand_form(), zero_at, tail);
  endtask

  initial begin
    int unsigned phase;
    int unsigned start_bytes;
    int unsigned start_lines;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    out_ready = 1'b0;
    ready_hold = 0;
    bytes_sent = 0;
    lines_sent = 0;
    send_idle_pct = 17;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    // receiver idles, then sender idles, then neither; the last phase opens
    // with a long receiver hold-off so the block backs up on its input
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          ready_hold = 400;
        end
      endcase
      start_bytes = bytes_sent;
      start_lines = lines_sent;
      // results come one per line, so lines also bound the phase
      while (bytes_sent - start_bytes < 200 || lines_sent - start_lines < 20)
        random_line();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_line_scan.sv
hw/rtl/nsp_record.sv
hw/rtl/nmea_sentence_parser.sv
hw/rtl/nsp_checker.sv
tb/nmea_scoreboard_pkg.sv
tb/tb.sv
